// File: rtl/core/xpr_pkg.sv
`default_nettype none

package xpr_pkg;

  localparam logic [2:0] ReqClear   = 3'd0;
  localparam logic [2:0] ReqWrData  = 3'd1;
  localparam logic [2:0] ReqWrPar   = 3'd2;
  localparam logic [2:0] ReqRecover = 3'd3;
  localparam logic [2:0] ReqRead    = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  packet_index;
    logic [10:0] byte_offset;
    logic [7:0]  byte_value;
    logic        last_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [10:0] packet_length;
    logic        packet_present;
    logic        frame_complete;
    logic [6:0]  recovered_total;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_WDATA,
    OP_WPAR,
    OP_RECOVER,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e  op;
    logic idx_ok;
    req_t req;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/xpr_ram.sv
`default_nettype none

module xpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/xpr_front.sv
`default_nettype none

module xpr_front #(
  parameter int MAX_PACKETS = 64,
  parameter int MAX_PAYLOAD = 1200,
  parameter int INTERLEAVE  = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire xpr_pkg::req_t req_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output xpr_pkg::cmd_t      cmd_o
);

  import xpr_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop, off_ok;
  cmd_t       cls;

  always_comb begin
    off_ok     = int'(req_i.byte_offset) < MAX_PAYLOAD;
    cls.req    = req_i;
    cls.idx_ok = int'(req_i.packet_index) < MAX_PACKETS;
    case (req_i.req_type)
      ReqClear:   cls.op = OP_CLEAR;
      ReqWrData:  cls.op = (cls.idx_ok && off_ok) ? OP_WDATA : OP_NOP;
      ReqWrPar:   cls.op = (int'(req_i.packet_index) < INTERLEAVE && off_ok) ? OP_WPAR : OP_NOP;
      ReqRecover: cls.op = OP_RECOVER;
      ReqRead:    cls.op = OP_READ;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign busy        = (count_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/xpr_back.sv
`default_nettype none

module xpr_back #(
  parameter int MAX_PACKETS = 64,
  parameter int MAX_PAYLOAD = 1200,
  parameter int INTERLEAVE  = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [6:0]    packet_count_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire xpr_pkg::cmd_t cmd_i,
  output logic               rsp_valid_o,
  output xpr_pkg::rsp_t      rsp_o
);

  import xpr_pkg::*;

  localparam int PIW   = MAX_PACKETS > 1 ? $clog2(MAX_PACKETS) : 1;
  localparam int PW    = INTERLEAVE > 1 ? $clog2(INTERLEAVE) : 1;
  localparam int CW    = $clog2(MAX_PACKETS + INTERLEAVE);
  localparam int GW    = $clog2(INTERLEAVE + 1);
  localparam int LW    = $clog2(MAX_PAYLOAD + 1);
  localparam int DDEP  = MAX_PACKETS * MAX_PAYLOAD;
  localparam int PDEP  = INTERLEAVE * MAX_PAYLOAD;
  localparam int DAW   = DDEP > 1 ? $clog2(DDEP) : 1;
  localparam int PAW   = PDEP > 1 ? $clog2(PDEP) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_CHECK, S_PRD, S_PWAIT, S_MISS, S_MWAIT,
    S_WR, S_FIN, S_LOOK, S_RESP
  } state_e;

  state_e               state_q;
  cmd_t                 cmd_q;
  logic [CW-1:0]        n_q, i_q;
  logic [GW-1:0]        g_q;
  logic [1:0]           miss_q;
  logic [PIW-1:0]       lost_q;
  logic [LW-1:0]        b_q, len_q;
  logic [7:0]           acc_q;
  logic [MAX_PACKETS-1:0] valid_q;
  logic [INTERLEAVE-1:0]  pvalid_q;
  logic [LW-1:0]        plen_q [INTERLEAVE];
  logic [6:0]           cnt_q;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;

  logic                 d_we, l_we, p_we;
  logic [DAW-1:0]       d_waddr, d_raddr;
  logic [7:0]           d_wdata, d_rdata;
  logic [PIW-1:0]       l_waddr, l_raddr;
  logic [LW-1:0]        l_wdata, l_rdata;
  logic [PAW-1:0]       p_waddr, p_raddr;
  logic [7:0]           p_rdata;
  logic [PIW-1:0]       idx_p, i_p;
  logic [PW-1:0]        g_p, pidx_p;
  logic [CW-1:0]        n_eff;
  logic [GW-1:0]        groups;
  logic                 frame_done, i_in;
  logic [MAX_PACKETS-1:0] mask;

  function automatic logic [DAW-1:0] daddr(input int pkt, input int off);
    daddr = DAW'(pkt * MAX_PAYLOAD + off);
  endfunction

  function automatic logic [PAW-1:0] paddr(input int grp, input int off);
    paddr = PAW'(grp * MAX_PAYLOAD + off);
  endfunction

  assign idx_p  = PIW'(cmd_q.req.packet_index);
  assign pidx_p = PW'(cmd_q.req.packet_index);
  assign i_p    = i_q[PIW-1:0];
  assign g_p    = g_q[PW-1:0];
  assign i_in   = i_q < n_q;
  assign n_eff  = (int'(packet_count_i) > MAX_PACKETS) ? CW'(MAX_PACKETS) : CW'(packet_count_i);
  assign groups = (int'(n_q) < INTERLEAVE) ? GW'(n_q) : GW'(INTERLEAVE);

  always_comb begin
    for (int k = 0; k < MAX_PACKETS; k++) begin
      mask[k] = (k < int'(n_q));
    end
    frame_done = (n_q != '0) && ((valid_q | ~mask) == '1);
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = cmd_q.req.byte_value;
    d_raddr = '0;
    l_we    = 1'b0;
    l_waddr = idx_p;
    l_wdata = LW'(int'(cmd_q.req.byte_offset) + 1);
    l_raddr = idx_p;
    p_we    = 1'b0;
    p_waddr = paddr(int'(pidx_p), int'(cmd_q.req.byte_offset));
    p_raddr = paddr(int'(g_p), int'(b_q));
    case (state_q)
      S_EXEC: begin
        d_waddr = daddr(int'(idx_p), int'(cmd_q.req.byte_offset));
        if (cmd_q.op == OP_WDATA) begin
          d_we = 1'b1;
          l_we = cmd_q.req.last_byte;
        end
        p_we = (cmd_q.op == OP_WPAR);
      end
      S_MISS: begin
        l_raddr = i_p;
        d_raddr = daddr(int'(i_p), int'(b_q));
      end
      S_WR: begin
        d_we    = 1'b1;
        d_waddr = daddr(int'(lost_q), int'(b_q));
        d_wdata = acc_q;
      end
      S_FIN: begin
        l_we    = 1'b1;
        l_waddr = lost_q;
        l_wdata = len_q;
      end
      S_LOOK: begin
        if (cmd_q.idx_ok && int'(cmd_q.req.byte_offset) < MAX_PAYLOAD) begin
          d_raddr = daddr(int'(idx_p), int'(cmd_q.req.byte_offset));
        end
      end
      default: ;
    endcase
  end

  xpr_ram #(.WIDTH(8), .DEPTH(DDEP)) u_data (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  xpr_ram #(.WIDTH(LW), .DEPTH(MAX_PACKETS)) u_len (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  xpr_ram #(.WIDTH(8), .DEPTH(PDEP)) u_par (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(cmd_q.req.byte_value),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      pvalid_q    <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      n_q         <= '0;
      g_q         <= '0;
      i_q         <= '0;
      miss_q      <= '0;
      lost_q      <= '0;
      b_q         <= '0;
      len_q       <= '0;
      acc_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            n_q     <= n_eff;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_LOOK;
          case (cmd_q.op)
            OP_CLEAR: begin
              valid_q  <= '0;
              pvalid_q <= '0;
              cnt_q    <= '0;
            end
            OP_WDATA: begin
              if (cmd_q.req.last_byte) begin
                valid_q[idx_p] <= 1'b1;
              end
            end
            OP_WPAR: begin
              if (cmd_q.req.last_byte) begin
                pvalid_q[pidx_p] <= 1'b1;
                plen_q[pidx_p]   <= l_wdata;
              end
            end
            OP_RECOVER: begin
              if (n_q != '0 && !frame_done) begin
                g_q     <= '0;
                i_q     <= '0;
                miss_q  <= '0;
                state_q <= S_SCAN;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (i_in) begin
            if (!valid_q[i_p]) begin
              if (miss_q != 2'd2) begin
                miss_q <= miss_q + 2'd1;
              end
              lost_q <= i_p;
            end
            i_q <= i_q + CW'(INTERLEAVE);
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (miss_q == 2'd1 && pvalid_q[g_p] && plen_q[g_p] != '0) begin
            len_q   <= plen_q[g_p];
            b_q     <= '0;
            state_q <= S_PRD;
          end else if (g_q + GW'(1) == groups) begin
            state_q <= S_LOOK;
          end else begin
            g_q     <= g_q + GW'(1);
            i_q     <= CW'(g_q + GW'(1));
            miss_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_PRD: state_q <= S_PWAIT;
        S_PWAIT: begin
          acc_q   <= p_rdata;
          i_q     <= CW'(g_q);
          state_q <= S_MISS;
        end
        S_MISS: begin
          if (!i_in) begin
            state_q <= S_WR;
          end else if (i_q == CW'(lost_q)) begin
            i_q <= i_q + CW'(INTERLEAVE);
          end else begin
            state_q <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (b_q < l_rdata) begin
            acc_q <= acc_q ^ d_rdata;
          end
          i_q     <= i_q + CW'(INTERLEAVE);
          state_q <= S_MISS;
        end
        S_WR: begin
          b_q     <= b_q + LW'(1);
          state_q <= (b_q + LW'(1) == len_q) ? S_FIN : S_PRD;
        end
        S_FIN: begin
          valid_q[lost_q] <= 1'b1;
          if (cnt_q != 7'd127) begin
            cnt_q <= cnt_q + 7'd1;
          end
          if (g_q + GW'(1) == groups) begin
            state_q <= S_LOOK;
          end else begin
            g_q     <= g_q + GW'(1);
            i_q     <= CW'(g_q + GW'(1));
            miss_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_LOOK: state_q <= S_RESP;
        S_RESP: begin
          rsp_valid_q <= 1'b1;
          if (cmd_q.idx_ok && valid_q[idx_p]) begin
            rsp_q.packet_length  <= 11'(l_rdata);
            rsp_q.packet_present <= 1'b1;
          end else begin
            rsp_q.packet_length  <= '0;
            rsp_q.packet_present <= 1'b0;
          end
          if (cmd_q.op == OP_READ && cmd_q.idx_ok && valid_q[idx_p] &&
              cmd_q.req.byte_offset < 11'(l_rdata)) begin
            rsp_q.read_byte <= d_rdata;
          end else begin
            rsp_q.read_byte <= '0;
          end
          rsp_q.frame_complete  <= frame_done;
          rsp_q.recovered_total <= cnt_q;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o) |=> !cmd_ready_o)
    else $error("back took two commands back to back");

  a_rsp_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe longer than one cycle");

  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (state_q == S_IDLE || state_q == S_EXEC))
    else $error("result strobe while a command was in progress");

  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_we |-> (int'(d_waddr) < DDEP))
    else $error("data store write out of range");

endmodule

`default_nettype wire

// File: rtl/core/xor_parity_packet_recovery_unit.sv
`default_nettype none

// Frame store with interleaved XOR parity recovery. A request is taken on
// start while busy is low and returns exactly one result, marked by rsp_valid_o
// for one cycle; the receiver cannot stall it. A two entry command queue
// lets start be accepted while earlier requests are still executing. Recovery
// scans each group one member per cycle, then rebuilds the lost packet byte by
// byte, XORing its parity byte with each other member's byte, read through
// the single read port of the data store. The packet_count register may be
// written only while no request is outstanding.
module xor_parity_packet_recovery_unit #(
  parameter int MAX_PACKETS = 64,
  parameter int MAX_PAYLOAD = 1200,
  parameter int INTERLEAVE  = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [6:0]    cfg_wdata_i,
  input  wire logic          start,
  output logic               busy,
  input  wire xpr_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output xpr_pkg::rsp_t      rsp_o
);

  import xpr_pkg::*;

  logic [6:0] packet_count_q;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_count_q <= '0;
    end else if (cfg_valid_i) begin
      packet_count_q <= cfg_wdata_i;
    end
  end

  xpr_front #(
    .MAX_PACKETS(MAX_PACKETS), .MAX_PAYLOAD(MAX_PAYLOAD), .INTERLEAVE(INTERLEAVE)
  ) u_front (
    .clk_i, .rst_ni, .start, .busy, .req_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  xpr_back #(
    .MAX_PACKETS(MAX_PACKETS), .MAX_PAYLOAD(MAX_PAYLOAD), .INTERLEAVE(INTERLEAVE)
  ) u_back (
    .clk_i, .rst_ni, .packet_count_i(packet_count_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .rsp_valid_o, .rsp_o
  );

endmodule

`default_nettype wire

// File: tb/recovery_checker.sv
`timescale 1ns / 1ps

module recovery_checker
  import xpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [6:0] cfg_wdata_i,
  input  logic       start,
  input  logic       busy,
  input  req_t       req_i,
  input  logic       rsp_valid_o,
  input  rsp_t       rsp_o,
  output int         errors_o,
  output int         pending_o,
  output int         items_o,
  output int         recoveries_o
);

  localparam int NumPackets = 64;
  localparam int Payload    = 1200;
  localparam int Groups     = 4;

  logic [7:0]  data_mem   [NumPackets*Payload];
  logic [10:0] data_len   [NumPackets];
  logic        data_ok    [NumPackets];
  logic [7:0]  parity_mem [Groups*Payload];
  logic [10:0] parity_len [Groups];
  logic        parity_ok  [Groups];
  int          rebuilt_cnt;
  int          frame_size;
  rsp_t        expected_q [$];

  initial begin
    foreach (data_mem[i]) data_mem[i] = '0;
    foreach (parity_mem[i]) parity_mem[i] = '0;
    foreach (data_len[i]) data_len[i] = '0;
    foreach (parity_len[i]) parity_len[i] = '0;
    foreach (data_ok[i]) data_ok[i] = 1'b0;
    foreach (parity_ok[i]) parity_ok[i] = 1'b0;
    rebuilt_cnt = 0;
    frame_size = 0;
    errors_o = 0;
    pending_o = 0;
    items_o = 0;
    recoveries_o = 0;
  end

  function automatic int used_packets();
    return (frame_size > NumPackets) ? NumPackets : frame_size;
  endfunction

  function automatic logic frame_is_complete();
    int n;
    n = used_packets();
    if (n == 0) return 1'b0;
    for (int i = 0; i < n; i++) if (!data_ok[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void rebuild_missing();
    int n;
    int grp_cnt;
    int missing;
    int lost;
    int plen;
    logic [7:0] acc;
    n = used_packets();
    grp_cnt = (n < Groups) ? n : Groups;
    if (n == 0 || frame_is_complete()) return;
    for (int g = 0; g < grp_cnt; g++) begin
      missing = 0;
      lost = 0;
      for (int i = g; i < n; i += Groups) begin
        if (!data_ok[i]) begin
          missing++;
          lost = i;
        end
      end
      if (missing != 1 || !parity_ok[g]) continue;
      plen = int'(parity_len[g]);
      if (plen > Payload) plen = Payload;
      for (int b = 0; b < plen; b++) begin
        acc = parity_mem[g*Payload+b];
        for (int i = g; i < n; i += Groups) begin
          if (i != lost && b < data_len[i]) acc ^= data_mem[i*Payload+b];
        end
        data_mem[lost*Payload+b] = acc;
      end
      data_len[lost] = plen[10:0];
      data_ok[lost] = 1'b1;
      if (rebuilt_cnt < 127) rebuilt_cnt++;
      recoveries_o++;
    end
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int idx;
    int off;
    idx = int'(r.packet_index);
    off = int'(r.byte_offset);
    res = '0;
    case (r.req_type)
      ReqClear: begin
        foreach (data_ok[i]) data_ok[i] = 1'b0;
        foreach (parity_ok[i]) parity_ok[i] = 1'b0;
        rebuilt_cnt = 0;
      end
      ReqWrData: begin
        if (off < Payload) begin
          data_mem[idx*Payload+off] = r.byte_value;
          if (r.last_byte) begin
            data_len[idx] = 11'(off + 1);
            data_ok[idx] = 1'b1;
          end
        end
      end
      ReqWrPar: begin
        if (idx < Groups && off < Payload) begin
          parity_mem[idx*Payload+off] = r.byte_value;
          if (r.last_byte) begin
            parity_len[idx] = 11'(off + 1);
            parity_ok[idx] = 1'b1;
          end
        end
      end
      ReqRecover: rebuild_missing();
      ReqRead: begin
        if (data_ok[idx] && off < data_len[idx] && off < Payload)
          res.read_byte = data_mem[idx*Payload+off];
      end
      default: ;
    endcase
    if (data_ok[idx]) begin
      res.packet_length = data_len[idx];
      res.packet_present = 1'b1;
    end
    res.frame_complete = frame_is_complete();
    res.recovered_total = rebuilt_cnt[6:0];
    return res;
  endfunction

  function automatic void queue_expected(rsp_t r);
    expected_q = {expected_q, r};
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (!rst_ni) begin
      foreach (data_ok[i]) data_ok[i] = 1'b0;
      foreach (parity_ok[i]) parity_ok[i] = 1'b0;
      rebuilt_cnt = 0;
      frame_size = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) frame_size = int'(cfg_wdata_i);
      if (start && !busy) begin
        queue_expected(apply_request(req_i));
        items_o++;
      end
      if (rsp_valid_o) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_o);
        end else begin
          exp_r = expected_q.pop_front();
          check_field("read_byte", int'(exp_r.read_byte), int'(rsp_o.read_byte));
          check_field("packet_length", int'(exp_r.packet_length),
                      int'(rsp_o.packet_length));
          check_field("packet_present", int'(exp_r.packet_present),
                      int'(rsp_o.packet_present));
          check_field("frame_complete", int'(exp_r.frame_complete),
                      int'(rsp_o.frame_complete));
          check_field("recovered_total", int'(exp_r.recovered_total),
                      int'(rsp_o.recovered_total));
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import xpr_pkg::*;

  localparam logic [2:0] ReqSpare5 = 3'd5;
  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [6:0] cfg_wdata_i;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       rsp_valid_o;
  rsp_t       rsp_o;
  int         errors;
  int         pending;
  int         items;
  int         recoveries;
  int         idle_pct;
  int         data_written [64];
  int         parity_written [4];
  int         frames;

  xor_parity_packet_recovery_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  recovery_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .items_o     (items),
    .recoveries_o(recoveries)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("testbench failed");
    $finish;
  end

  task automatic send(input logic [2:0] kind, input int idx, input int off,
                      input int val, input bit is_last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    req_i <= '{req_type: kind, packet_index: idx[5:0], byte_offset: off[10:0],
               byte_value: val[7:0], last_byte: is_last};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(input int value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_packet(input logic [2:0] kind, input int idx, input int len);
    for (int b = 0; b < len; b++) send(kind, idx, b, $urandom_range(255), b == len - 1);
    if (kind == ReqWrData) begin
      if (data_written[idx] < len) data_written[idx] = len;
    end else if (parity_written[idx] < len) begin
      parity_written[idx] = len;
    end
  endtask

  task automatic noise_item();
    int kind;
    int idx;
    int off;
    int limit;
    kind = $urandom_range(7);
    idx = $urandom_range(63);
    off = ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(15);
    if (kind == ReqWrData || kind == ReqWrPar) begin
      limit = (kind == ReqWrData) ? data_written[idx] :
              (idx < 4) ? parity_written[idx] : 2048;
      if (off >= 1200 || off <= limit) begin
        send(kind[2:0], idx, off, $urandom_range(255), $urandom_range(1));
        if (off == limit && off < 1200) begin
          if (kind == ReqWrData) data_written[idx]++;
          else if (idx < 4) parity_written[idx]++;
        end
      end else begin
        send(kind[2:0], idx, off, $urandom_range(255), 1'b0);
      end
    end else if (kind != ReqClear) begin
      send(kind[2:0], idx, off, $urandom_range(255), $urandom_range(1));
    end
  endtask

  task automatic run_frame(input int count, input int max_len);
    int n;
    int drop;
    int groups;
    n = (count > 64) ? 64 : count;
    groups = (n < 4) ? n : 4;
    send(ReqClear, $urandom_range(63), 0, 0, 1'b0);
    for (int i = 0; i < n; i++) begin
      drop = $urandom_range(99);
      if (drop >= 25 || i >= n - 1) write_packet(ReqWrData, i, $urandom_range(1, max_len));
    end
    for (int g = 0; g < 4; g++) begin
      if (g >= groups || $urandom_range(9) != 0)
        write_packet(ReqWrPar, g, $urandom_range(1, max_len + 2));
    end
    if ($urandom_range(1)) noise_item();
    send(ReqRecover, $urandom_range(63), 0, 0, 1'b0);
    for (int k = 0; k < 6; k++) begin
      send(ReqRead, $urandom_range(n > 0 ? n - 1 : 63), $urandom_range(max_len + 2),
           $urandom_range(255), $urandom_range(1));
    end
    send(ReqRecover, 0, 0, 0, 1'b0);
    repeat ($urandom_range(3)) noise_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wdata_i = '0;
    start = 1'b0;
    req_i = '0;
    idle_pct = 34;
    foreach (data_written[i]) data_written[i] = 0;
    foreach (parity_written[i]) parity_written[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_count(0);
    send(ReqRead, 0, 0, 0, 1'b0);
    send(ReqSpare5, 63, 2047, 255, 1'b1);
    send(ReqSpare6, 1, 1, 1, 1'b0);
    send(ReqSpare7, 2, 3, 4, 1'b1);
    send(ReqRecover, 0, 0, 0, 1'b0);
    send(ReqWrPar, 63, 0, 255, 1'b1);
    send(ReqWrData, 7, 2047, 255, 1'b1);
    send(ReqRead, 7, 2047, 0, 1'b0);

    write_count(5);
    send(ReqClear, 0, 0, 0, 1'b0);
    write_packet(ReqWrData, 0, 2);
    write_packet(ReqWrData, 1, 3);
    write_packet(ReqWrData, 2, 1);
    write_packet(ReqWrData, 3, 2);
    write_packet(ReqWrPar, 0, 200);
    send(ReqRead, 4, 0, 0, 1'b0);
    send(ReqRecover, 0, 0, 0, 1'b0);
    send(ReqRead, 4, 199, 0, 1'b0);
    send(ReqRead, 4, 0, 0, 1'b0);
    send(ReqRead, 4, 200, 0, 1'b0);
    send(ReqRead, 4, 1199, 0, 1'b0);
    send(ReqRecover, 0, 0, 0, 1'b0);
    send(ReqWrData, 4, 0, 0, 1'b1);
    send(ReqRead, 4, 0, 255, 1'b0);
    send(ReqClear, 0, 0, 0, 1'b0);
    send(ReqRead, 4, 0, 0, 1'b0);

    frames = 9;
    for (int f = 0; f < frames; f++) begin
      int count;
      idle_pct = (f < frames / 3) ? 34 : (f < 2 * frames / 3) ? 87 : 0;
      case (f % 9)
        0: count = 127;
        1: count = 64;
        2: count = 1;
        3: count = 0;
        default: count = $urandom_range(2, 12);
      endcase
      write_count(count);
      run_frame(count, (count >= 64) ? 2 : 6);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests over %0d frames with %0d packet rebuilds.",
             items, frames + 2, recoveries);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/xpr_pkg.sv
rtl/core/xpr_ram.sv
rtl/core/xpr_front.sv
rtl/core/xpr_back.sv
rtl/core/xor_parity_packet_recovery_unit.sv
tb/recovery_checker.sv
tb/testbench.sv
